FILE: src/fspb_pkg.sv
// ----------------------------------------------------------------------------
// fspb_pkg: shared types and constants for the fair share page budget block
// Widths of the request and result fields, the walk sequencer states and the
// interface between the chain cells and the top level.
// ----------------------------------------------------------------------------
package fspb_pkg;

  localparam int IdW     = 4;
  localparam int BytesW  = 36;
  localparam int PagesW  = 24;
  localparam int DemandW = 40;
  localparam logic [DemandW-1:0] DemandMax = {DemandW{1'b1}};
  localparam logic [PagesW-1:0] TotalReset = 24'd1048576;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_SORT,
    ST_LOAD,
    ST_DIV,
    ST_GRANT,
    ST_SHARE_DIV,
    ST_SPLIT,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic               acc_en;
    logic [IdW-1:0]     acc_id;
    logic [DemandW-1:0] acc_pages;
    logic               sort_en;
    logic               parity;
    logic               clear;
  } cell_ctrl_t;

endpackage

FILE: src/fspb_if.sv
// ----------------------------------------------------------------------------
// fspb_req_if / fspb_res_if: valid/ready channels
// Request carries one kernel record; result carries one budget.
// ----------------------------------------------------------------------------
interface fspb_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  app_id;
  logic [35:0] kernel_bytes;
  logic        last_kernel;
  modport source (output valid, app_id, kernel_bytes, last_kernel, input ready);
  modport sink   (input valid, app_id, kernel_bytes, last_kernel, output ready);
endinterface

interface fspb_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_app_id;
  logic [23:0] budget_pages;
  logic        last_budget;
  modport source (output valid, out_app_id, budget_pages, last_budget, input ready);
  modport sink   (input valid, out_app_id, budget_pages, last_budget, output ready);
endinterface

FILE: src/fspb_divider.sv
// ----------------------------------------------------------------------------
// fspb_divider: restoring divider, one quotient bit per cycle
// Divides a 24-bit dividend by a narrow divisor.
// ----------------------------------------------------------------------------
module fspb_divider #(
  parameter int DW = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fspb_pkg::PagesW-1:0] dividend,
  input  logic [DW-1:0]            divisor,
  output logic                     done,
  output logic [fspb_pkg::PagesW-1:0] quotient
);
  import fspb_pkg::*;

  localparam int CntW = $clog2(PagesW + 1);

  logic [PagesW-1:0] quo;
  logic [DW:0]       rem;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic [DW:0]       trial;

  assign trial = {rem[DW-1:0], quo[PagesW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(PagesW);
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          quo <= {quo[PagesW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[PagesW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule

FILE: src/fspb_cell.sv
// ----------------------------------------------------------------------------
// fspb_cell: one slot of the sorting chain
// Holds one application's id and demand; compares with its neighbor in
// odd-even transposition steps and trades entries with it on a swap.
// ----------------------------------------------------------------------------
module fspb_cell #(
  parameter int AW  = 4,
  parameter int POS = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fspb_pkg::cell_ctrl_t         ctrl,
  input  logic                         nb_present,
  input  logic [AW-1:0]                nb_id,
  input  logic [fspb_pkg::DemandW-1:0] nb_demand,
  input  logic                         pv_present,
  input  logic [AW-1:0]                pv_id,
  input  logic [fspb_pkg::DemandW-1:0] pv_demand,
  output logic                         present,
  output logic [AW-1:0]                id,
  output logic [fspb_pkg::DemandW-1:0] demand
);
  import fspb_pkg::*;

  logic [DemandW:0] sum;
  logic             is_left;
  logic             pair_on;
  logic             swap;
  logic             key_gt;

  assign sum = {1'b0, demand} + {1'b0, ctrl.acc_pages};
  assign is_left = ((POS % 2) == 0) ^ ctrl.parity;
  // cell is left of a pair: compares with next; right: with previous
  assign key_gt = is_left ?
      (present && (!nb_present ? 1'b1 :
        (demand > nb_demand) || (demand == nb_demand && id > nb_id))) & nb_present :
      (pv_present && (!present ? 1'b1 :
        (pv_demand > demand) || (pv_demand == demand && pv_id > id))) & present;
  // absent cells sink to the tail
  assign swap = is_left ? ((present && nb_present && key_gt) || (!present && nb_present))
                        : ((pv_present && present && key_gt) || (!pv_present && present));
  // hold the head when it has no left partner
  assign pair_on = is_left || (POS != 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      demand  <= '0;
      id      <= AW'(POS);
    end else if (ctrl.clear) begin
      present <= 1'b0;
      demand  <= '0;
      id      <= AW'(POS);
    end else if (ctrl.acc_en) begin
      if (int'(ctrl.acc_id) == POS && id == AW'(POS)) begin
        present <= 1'b1;
        demand  <= sum[DemandW] ? DemandMax : sum[DemandW-1:0];
      end
    end else if (ctrl.sort_en && pair_on && swap) begin
      if (is_left) begin
        present <= nb_present; id <= nb_id; demand <= nb_demand;
      end else begin
        present <= pv_present; id <= pv_id; demand <= pv_demand;
      end
    end
  end
endmodule

FILE: src/fair_share_page_budget_core.sv
// ----------------------------------------------------------------------------
// fair_share_page_budget_core: max-min fair share of device pages
// Accumulates per-application page demand, sorts on the last request and
// walks the sorted chain granting pages, then emits one budget each.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | app_id, kernel_bytes, last_kernel
//  res     | out | out_app_id, budget_pages, last_budget
//  cfg     | in  | cfg_we, cfg_wdata (total_pages)
// A non-last request is accepted, then accumulated; PAGE_BYTES is a power of two.
// A last request is accumulated, then the chain is sorted, then per application
// come a load, a wait (on the divider when its demand is cut) and a grant; then a
// load, a wait on the divider for the even share and a split, then the results are
// emitted in order and the chain is cleared.
// Reset clears all demand; results stall on res.ready without loss.
module fair_share_page_budget_core #(
  parameter int MAX_APPS   = 16,
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [23:0]       cfg_wdata,
  fspb_req_if.sink          req,
  fspb_res_if.source        res
);
  import fspb_pkg::*;

  localparam int AW     = $clog2(MAX_APPS);
  localparam int CW     = $clog2(MAX_APPS + 1);
  localparam int PageSh = $clog2(PAGE_BYTES);

  state_t state, state_next;

  logic [PagesW-1:0]  total_pages;
  logic [IdW-1:0]     r_id;
  logic [BytesW-1:0]  r_bytes;
  logic               r_last;
  logic               req_last_q;
  logic [DemandW-1:0] r_pages;
  logic [CW-1:0]      step, count, idx;
  logic [PagesW-1:0]  remaining, share, extra;
  logic               div_start, div_done;
  logic [PagesW-1:0]  div_a, div_q;
  logic [CW-1:0]      div_b;
  logic               parity;
  logic               first_done;

  cell_ctrl_t ctrl;

  logic               c_pres  [MAX_APPS+1];
  logic [AW-1:0]      c_id    [MAX_APPS+1];
  logic [DemandW-1:0] c_dem   [MAX_APPS+1];

  assign r_pages = DemandW'(r_bytes >> PageSh) +
                   DemandW'(|(r_bytes & BytesW'(PAGE_BYTES - 1)));

  always_ff @(posedge clk) begin
    if (rst) total_pages <= TotalReset;
    else if (cfg_we) total_pages <= cfg_wdata;
  end

  assign c_pres[MAX_APPS]  = 1'b0;
  assign c_id[MAX_APPS]    = '0;
  assign c_dem[MAX_APPS]   = '0;

  for (genvar g = 0; g < MAX_APPS; g++) begin : g_cell
    if (g == 0) begin : g_head
      fspb_cell #(.AW(AW), .POS(g)) u_cell (
        .clk, .rst, .ctrl,
        .nb_present(c_pres[g+1]), .nb_id(c_id[g+1]), .nb_demand(c_dem[g+1]),
        .pv_present(1'b0), .pv_id('0), .pv_demand('0),
        .present(c_pres[g]), .id(c_id[g]), .demand(c_dem[g]));
    end else begin : g_body
      fspb_cell #(.AW(AW), .POS(g)) u_cell (
        .clk, .rst, .ctrl,
        .nb_present(c_pres[g+1]), .nb_id(c_id[g+1]), .nb_demand(c_dem[g+1]),
        .pv_present(c_pres[g-1]), .pv_id(c_id[g-1]), .pv_demand(c_dem[g-1]),
        .present(c_pres[g]), .id(c_id[g]), .demand(c_dem[g]));
    end
  end

  fspb_divider #(.DW(CW)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q));

  // grant table: one granted id and page count per sorted position, indexed by idx
  logic [AW-1:0]     g_id   [MAX_APPS];
  logic [PagesW-1:0] g_val  [MAX_APPS];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM:     if (r_last) state_next = ST_SORT;
      ST_SORT:      if (step == CW'(MAX_APPS)) state_next = ST_LOAD;
      ST_LOAD:      state_next = (count == '0) ? ST_CLEAR :
                                 (idx == count) ? ST_SHARE_DIV : ST_DIV;
      ST_DIV:       if (div_done || first_done) state_next = ST_GRANT;
      ST_GRANT:     state_next = ST_LOAD;
      ST_SHARE_DIV: if (div_done) state_next = ST_SPLIT;
      ST_SPLIT:     state_next = ST_EMIT;
      ST_EMIT:      if (res.ready && idx == count - 1'b1) state_next = ST_CLEAR;
      ST_CLEAR:     state_next = ST_ACCUM;
      default:      state_next = ST_ACCUM;
    endcase
  end

  logic busy_in;
  assign req.ready = (state == ST_ACCUM) && !busy_in;

  always_comb begin
    ctrl = '0;
    ctrl.acc_id    = r_id;
    ctrl.acc_pages = r_pages;
    ctrl.parity    = parity;
    ctrl.acc_en    = (state == ST_ACCUM) && busy_in && (int'(r_id) < MAX_APPS);
    ctrl.sort_en   = (state == ST_SORT) && (step != CW'(MAX_APPS));
    ctrl.clear     = (state == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ACCUM;
      busy_in <= 1'b0;
      r_last  <= 1'b0;
      step    <= '0;
      idx     <= '0;
      count   <= '0;
      parity  <= 1'b0;
      div_start <= 1'b0;
      first_done <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= 1'b0;
      first_done <= 1'b0;
      unique case (state)
        ST_ACCUM: begin
          if (req.valid && req.ready) begin
            r_id    <= req.app_id;
            r_bytes <= req.kernel_bytes;
            busy_in <= 1'b1;
            r_last  <= 1'b0;
          end else if (busy_in) begin
            busy_in <= 1'b0;
            r_last  <= req_last_q;
          end else begin
            r_last <= 1'b0;
          end
          step <= '0; parity <= 1'b0;
        end
        ST_SORT: begin
          step   <= step + 1'b1;
          parity <= ~parity;
          idx    <= '0;
          remaining <= total_pages;
          count  <= '0;
          if (step == CW'(MAX_APPS)) begin
            for (int k = 0; k < MAX_APPS; k++)
              if (c_pres[k]) count <= CW'(k + 1);
          end
        end
        ST_LOAD: begin
          if (idx != count) begin
            if ({16'd0, remaining} < c_dem[idx[AW-1:0]]) begin
              div_a <= remaining; div_b <= count - idx; div_start <= 1'b1;
            end else first_done <= 1'b1;
          end else begin
            div_a <= remaining; div_b <= count; div_start <= 1'b1;
          end
        end
        ST_DIV: ;
        ST_GRANT: begin
          g_id[idx[AW-1:0]] <= c_id[idx[AW-1:0]];
          if ({16'd0, remaining} < c_dem[idx[AW-1:0]]) begin
            g_val[idx[AW-1:0]] <= div_q;
            remaining <= remaining - div_q;
          end else begin
            g_val[idx[AW-1:0]] <= c_dem[idx[AW-1:0]][PagesW-1:0];
            remaining <= remaining - c_dem[idx[AW-1:0]][PagesW-1:0];
          end
          idx <= idx + 1'b1;
        end
        ST_SHARE_DIV: begin
          if (div_done) share <= div_q;
        end
        ST_SPLIT: begin
          extra <= remaining - PagesW'(share * count);
          idx   <= '0;
        end
        ST_EMIT: begin
          if (res.ready) idx <= idx + 1'b1;
        end
        ST_CLEAR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) req_last_q <= req.last_kernel;
  end

  assign res.valid        = (state == ST_EMIT);
  assign res.out_app_id   = IdW'(g_id[idx[AW-1:0]]);
  assign res.budget_pages = g_val[idx[AW-1:0]] + share +
                            ((PagesW'(idx) < extra) ? 24'd1 : 24'd0);
  assign res.last_budget  = (idx == count - 1'b1);
endmodule

FILE: bench/fair_share_page_budget_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fair_share_page_budget_core_tb: self-checking bench for the page budget core
// Drives kernel requests in runs closed by a last request, predicts the max-min
// fair share budgets of each run and checks every budget in order, under random
// request gaps, result stalls and several total_pages settings.
// ----------------------------------------------------------------------------
module fair_share_page_budget_core_tb;
  import fspb_pkg::*;

  localparam int NumApps   = 16;
  localparam int PageBytes = 4096;

  typedef struct packed {
    logic [IdW-1:0]    app_id;
    logic [PagesW-1:0] pages;
    logic              last;
  } budget_t;

  class budget_board;
    logic [DemandW-1:0] demand [NumApps];
    bit                 present [NumApps];
    logic [PagesW-1:0]  total;
    budget_t            pending [$];
    int                 errors;

    function void wipe();
      foreach (demand[i]) begin
        demand[i] = '0;
        present[i] = 0;
      end
    endfunction

    function void note_request(logic [IdW-1:0] id, logic [BytesW-1:0] bytes, logic last);
      logic [DemandW:0]   sum;
      logic [DemandW-1:0] pages;
      int                 order [NumApps];
      logic [63:0]        grant [NumApps];
      logic [63:0]        remaining;
      logic [63:0]        share;
      int                 n;
      int                 j;
      budget_t            b;
      pages = ({4'd0, bytes} + PageBytes - 1) / PageBytes;
      sum = {1'b0, demand[id]} + {1'b0, pages};
      demand[id] = sum > {1'b0, DemandMax} ? DemandMax : sum[DemandW-1:0];
      present[id] = 1;
      if (!last) return;
      n = 0;
      share = '0;
      for (int i = 0; i < NumApps; i++) begin
        if (!present[i]) continue;
        j = n;
        while (j > 0 && demand[order[j-1]] > demand[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        n++;
      end
      remaining = 64'(total);
      for (int i = 0; i < n; i++) begin
        grant[i] = 64'(demand[order[i]]);
        if (remaining < grant[i]) grant[i] = remaining / (n - i);
        remaining -= grant[i];
      end
      if (n > 0) begin
        share = remaining / n;
        remaining -= share * n;
      end
      for (int i = 0; i < n; i++) begin
        b.app_id = IdW'(order[i]);
        b.pages = PagesW'(grant[i] + share + (i < remaining ? 1 : 0));
        b.last = (i == n - 1);
        pending.push_back(b);
      end
      wipe();
    endfunction

    function void check_budget(budget_t got);
      budget_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected budget id=%0d pages=%0d last=%0b", $time,
                 got.app_id, got.pages, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.app_id !== want.app_id) begin
        $display("%0t: app id expected %0d actual %0d", $time, want.app_id, got.app_id);
        errors++;
      end
      if (got.pages !== want.pages) begin
        $display("%0t: budget expected %0d actual %0d", $time, want.pages, got.pages);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_we = 0;
  logic [PagesW-1:0] cfg_wdata = '0;
  int                stall_mode = 0;
  budget_board       board;

  fspb_req_if req ();
  fspb_res_if res ();

  fair_share_page_budget_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .res       (res.source)
  );

  always #6 clk = ~clk;

  initial begin
    req.valid = 0;
    req.app_id = '0;
    req.kernel_bytes = '0;
    req.last_kernel = 0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else begin
      case (stall_mode)
        0: res.ready <= 1;
        1: res.ready <= ($urandom_range(0, 3) != 0);
        2: res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= ($urandom_range(0, 19) != 0) ? res.ready : ~res.ready;
      endcase
      if (res.valid && res.ready)
        board.check_budget('{res.out_app_id, res.budget_pages, res.last_budget});
    end
  end

  int burst_left = 0;

  task automatic end_burst();
    if (burst_left != 0) begin
      req.valid <= 0;
      burst_left = 0;
    end
  endtask

  task automatic send_request(logic [IdW-1:0] id, logic [BytesW-1:0] bytes, logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    req.valid <= 1;
    req.app_id <= id;
    req.kernel_bytes <= bytes;
    req.last_kernel <= last;
    do @(posedge clk); while (!req.ready);
    board.note_request(id, bytes, last);
    if (burst_left == 0) req.valid <= 0;
  endtask

  task automatic set_total(logic [PagesW-1:0] value);
    end_burst();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.total = value;
  endtask

  function automatic logic [BytesW-1:0] rand_bytes();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return BytesW'({$urandom, $urandom});
      2: return BytesW'($urandom_range(1, 9000));
      3: return {BytesW{1'b1}};
      default: return BytesW'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  task automatic random_run();
    int n;
    n = $urandom_range(0, 7);
    for (int i = 0; i < n; i++)
      send_request(IdW'($urandom_range(0, 15)), rand_bytes(), 0);
    send_request(IdW'($urandom_range(0, 15)), rand_bytes(), 1);
  endtask

  initial begin
    logic [PagesW-1:0] settings [5];
    board = new();
    board.wipe();
    board.total = TotalReset;
    board.errors = 0;
    settings = '{24'd1, 24'hFFFFFF, 24'd37, 24'd1000, 24'd0};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_request(0, 0, 1);
    send_request(15, {BytesW{1'b1}}, 0);
    send_request(15, {BytesW{1'b1}}, 0);
    send_request(3, 4096, 0);
    send_request(4, 4097, 0);
    send_request(5, 1, 0);
    send_request(6, 4096, 1);
    for (int i = 0; i < 16; i++)
      send_request(IdW'(i), BytesW'((i % 3) * 4096 * 70000), i == 15);
    for (int s = 0; s < 5; s++) begin
      set_total(settings[s]);
      stall_mode = s % 4;
      for (int r = 0; r < 11; r++) random_run();
    end
    set_total(PagesW'($urandom_range(1, 24'hFFFFFF)));
    stall_mode = 3;
    for (int r = 0; r < 10; r++) random_run();
    end_burst();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: sim.f
src/fspb_pkg.sv
src/fspb_if.sv
src/fspb_divider.sv
src/fspb_cell.sv
src/fair_share_page_budget_core.sv
bench/fair_share_page_budget_core_tb.sv
